[hdl/efb_pkg.sv]
// ----------------------------------------------------------------------------
// Event fragment builder package
// Shared constants, codes and types for the fragment builder blocks.
// ----------------------------------------------------------------------------
package efb_pkg;

    localparam int NUM_CHANNELS = 2;
    localparam int MAX_PENDING  = 16;
    localparam int FIFO_DEPTH   = 2;

    localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int IDX_W   = $clog2(MAX_PENDING);
    localparam int SLOT_W  = IDX_W + CH_W;
    localparam int SLOTS   = MAX_PENDING * NUM_CHANNELS;
    localparam int PCNT_W  = $clog2(MAX_PENDING + 1);
    localparam int FCNT_W  = $clog2(NUM_CHANNELS + 1);
    localparam int BYTES_W = 17;

    localparam logic [15:0]      NO_BUNCH  = 16'hFFFF;
    localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};

    // Result kinds.
    localparam logic [1:0] KIND_COMPLETE   = 2'd0;
    localparam logic [1:0] KIND_FORCED     = 2'd1;
    localparam logic [1:0] KIND_MONITORING = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_MAX_PENDING = 2'd0;
    localparam logic [1:0] REG_MON_TAG     = 2'd1;
    localparam logic [1:0] REG_TRIG_MON    = 2'd2;
    localparam logic [1:0] REG_MIN_BYTES   = 2'd3;

    // Error flag bits.
    localparam int ERR_MISSING = 0;
    localparam int ERR_BUNCH   = 1;
    localparam int ERR_TAG     = 2;

    typedef struct packed {
        logic [7:0]  tag;
        logic [15:0] bunch_id;
        logic [15:0] bytes;
        logic [15:0] trigger;
        logic [15:0] status;
        logic [63:0] time_stamp;
    } frag_word_t;

    typedef struct packed {
        logic            monitoring;
        logic [CH_W-1:0] channel;
        logic [31:0]     evt_num;
        frag_word_t      frag;
    } queue_item_t;

    typedef struct packed {
        logic [7:0]         tag;
        logic [15:0]        trigger;
        logic [15:0]        bunch_id;
        logic [15:0]        status;
        logic [63:0]        time_stamp;
        logic [FCNT_W-1:0]  count;
        logic [2:0]         err;
        logic [BYTES_W-1:0] bytes;
    } acc_t;

    typedef struct packed {
        logic [1:0]              kind;
        logic [31:0]             evt_num;
        acc_t                    acc;
        logic [NUM_CHANNELS-1:0] mask;
    } result_t;

    localparam acc_t ACC_INIT = '{
        tag:        8'd0,
        trigger:    16'd0,
        bunch_id:   NO_BUNCH,
        status:     16'd0,
        time_stamp: 64'd0,
        count:      '0,
        err:        3'd0,
        bytes:      '0
    };

    // Folds one present fragment into the running merge.
    function automatic acc_t merge_frag(acc_t a, frag_word_t f);
        acc_t              r;
        logic [BYTES_W:0]  sum;
        r = a;
        sum = {1'b0, a.bytes} + {{(BYTES_W - 15){1'b0}}, f.bytes};
        r.status  = a.status | f.status;
        r.trigger = a.trigger | f.trigger;
        r.count   = a.count + FCNT_W'(1);
        r.bytes   = sum[BYTES_W] ? BYTES_MAX : sum[BYTES_W-1:0];
        if (a.time_stamp == 64'd0) begin
            r.time_stamp = f.time_stamp;
            r.bunch_id   = f.bunch_id;
            r.tag        = f.tag;
        end
        else begin
            if (a.bunch_id != f.bunch_id) r.err[ERR_BUNCH] = 1'b1;
            if (a.tag != f.tag) r.err[ERR_TAG] = 1'b1;
        end
        return r;
    endfunction

endpackage

[hdl/efb_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module efb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/efb_front.sv]
// ----------------------------------------------------------------------------
// Fragment front end
// Accepts fragments, drops undersized ones, marks monitoring fragments and
// queues the rest for the table sequencer.
// ----------------------------------------------------------------------------
module efb_front
    import efb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [CH_W-1:0]   channel,
    input  logic [31:0]       evt_num,
    input  logic [7:0]        frag_tag,
    input  logic [15:0]       trig_bits,
    input  logic [15:0]       bunch_id,
    input  logic [15:0]       frag_status,
    input  logic [63:0]       time_stamp,
    input  logic [15:0]       fragment_bytes,
    input  logic [7:0]        monitoring_tag,
    input  logic [7:0]        trigger_monitoring_tag,
    input  logic [15:0]       min_fragment_bytes,
    output logic              q_valid,
    output queue_item_t       q_item,
    input  logic              q_pop
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FCW   = $clog2(FIFO_DEPTH + 1);

    queue_item_t      fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [FCW-1:0]   fill_reg, fill_next;
    queue_item_t      item;
    logic             accept;
    logic             keep;
    logic             do_pop;

    assign full    = (fill_reg == FCW'(FIFO_DEPTH));
    assign q_valid = (fill_reg != '0);
    assign q_item  = fifo_reg[rptr_reg];
    assign accept  = push && !full;
    assign keep    = accept && (fragment_bytes >= min_fragment_bytes);
    assign do_pop  = q_pop && q_valid;

    always_comb
    begin
        item.monitoring      = (frag_tag == monitoring_tag) ||
                               (frag_tag == trigger_monitoring_tag);
        item.channel         = channel;
        item.evt_num         = evt_num;
        item.frag.tag        = frag_tag;
        item.frag.bunch_id   = bunch_id;
        item.frag.bytes      = fragment_bytes;
        item.frag.trigger    = trig_bits;
        item.frag.status     = frag_status;
        item.frag.time_stamp = time_stamp;

        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        fill_next = fill_reg;
        if (keep)
        begin
            wptr_next = (wptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr_reg + PTR_W'(1);
        end
        if (keep && !do_pop)
        begin
            fill_next = fill_reg + FCW'(1);
        end
        else if (!keep && do_pop)
        begin
            fill_next = fill_reg - FCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            fifo_reg[wptr_reg] <= item;
        end
    end

endmodule

[hdl/efb_back.sv]
// ----------------------------------------------------------------------------
// Pending event table sequencer
// Looks up, inserts and retires pending events, merges their stored
// fragments, passes monitoring fragments straight through and holds the result register.
// ----------------------------------------------------------------------------
module efb_back
    import efb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  queue_item_t q_item,
    output logic        q_pop,
    input  logic [3:0]  max_pending,
    output logic        out_valid,
    output result_t     out_result,
    input  logic        pop
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOOK = 3'd1;
    localparam logic [2:0] ST_INS  = 3'd2;
    localparam logic [2:0] ST_CHK  = 3'd3;
    localparam logic [2:0] ST_RD   = 3'd4;
    localparam logic [2:0] ST_ACC  = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;
    localparam logic [2:0] ST_MON  = 3'd7;

    localparam int FW = $bits(frag_word_t);

    logic [2:0]      state_reg, state_next;
    queue_item_t     cur_reg, cur_next;
    logic [IDX_W-1:0] tgt_reg, tgt_next;
    logic            new_reg, new_next;
    logic            produced_reg, produced_next;
    logic [IDX_W-1:0] emit_idx_reg, emit_idx_next;
    logic [1:0]      emit_kind_reg, emit_kind_next;
    logic            post_ins_reg, post_ins_next;
    logic [CH_W-1:0] rd_ch_reg, rd_ch_next;
    acc_t            acc_reg, acc_next;
    result_t         out_reg, out_next;
    logic            out_valid_reg, out_valid_next;

    logic [MAX_PENDING-1:0]  valid_reg;
    logic [31:0]             evnum_reg   [MAX_PENDING];
    logic [IDX_W-1:0]        rank_reg    [MAX_PENDING];
    logic [NUM_CHANNELS-1:0] present_reg [MAX_PENDING];
    logic [PCNT_W-1:0]       count_reg;

    logic             match_hit, free_hit, old_hit;
    logic [IDX_W-1:0] match_idx, free_idx, old_idx;
    logic             do_insert, do_remove;
    logic             out_free;
    logic             ram_we, ram_re;
    logic [SLOT_W-1:0] ram_waddr, ram_raddr;
    logic [FW-1:0]    ram_rdata;
    frag_word_t       rd_word;
    acc_t             acc_base;

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;
    assign out_free   = !out_valid_reg || pop;
    assign rd_word    = frag_word_t'(ram_rdata);
    assign acc_base   = (rd_ch_reg == '0) ? ACC_INIT : acc_reg;
    assign ram_waddr  = {tgt_reg, cur_reg.channel};
    assign ram_raddr  = {emit_idx_reg, rd_ch_reg};

    efb_ram #(
        .WIDTH (FW),
        .DEPTH (SLOTS)
    ) u_frag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cur_reg.frag),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Parallel search over the table: matching id, first free slot, oldest.
    always_comb
    begin
        match_hit = 1'b0;
        match_idx = '0;
        free_hit  = 1'b0;
        free_idx  = '0;
        old_hit   = 1'b0;
        old_idx   = '0;
        for (int i = MAX_PENDING - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (evnum_reg[i] == cur_reg.evt_num))
            begin
                match_hit = 1'b1;
                match_idx = IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_hit = 1'b1;
                free_idx = IDX_W'(i);
            end
            if (valid_reg[i] && (rank_reg[i] == '0))
            begin
                old_hit = 1'b1;
                old_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        tgt_next       = tgt_reg;
        new_next       = new_reg;
        produced_next  = produced_reg;
        emit_idx_next  = emit_idx_reg;
        emit_kind_next = emit_kind_reg;
        post_ins_next  = post_ins_reg;
        rd_ch_next     = rd_ch_reg;
        acc_next       = acc_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        do_insert      = 1'b0;
        do_remove      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop         = 1'b1;
                    cur_next      = q_item;
                    produced_next = 1'b0;
                    state_next    = q_item.monitoring ? ST_MON : ST_LOOK;
                end
            end
            ST_MON:
            begin
                if (out_free)
                begin
                    out_next.kind     = KIND_MONITORING;
                    out_next.evt_num  = cur_reg.evt_num;
                    out_next.acc      = merge_frag(ACC_INIT, cur_reg.frag);
                    out_next.mask     = '0;
                    out_next.mask[cur_reg.channel] = 1'b1;
                    out_valid_next    = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            ST_LOOK:
            begin
                if (match_hit)
                begin
                    tgt_next   = match_idx;
                    new_next   = 1'b0;
                    state_next = ST_INS;
                end
                else if (free_hit)
                begin
                    tgt_next   = free_idx;
                    new_next   = 1'b1;
                    state_next = ST_INS;
                end
                else if (old_hit)
                begin
                    // Table full: the oldest event leaves and its slot is reused.
                    tgt_next       = old_idx;
                    new_next       = 1'b1;
                    produced_next  = 1'b1;
                    emit_idx_next  = old_idx;
                    emit_kind_next = KIND_FORCED;
                    post_ins_next  = 1'b1;
                    rd_ch_next     = '0;
                    state_next     = ST_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_INS:
            begin
                ram_we     = 1'b1;
                do_insert  = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                rd_ch_next    = '0;
                post_ins_next = 1'b0;
                if (produced_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (&present_reg[tgt_reg])
                begin
                    emit_idx_next  = tgt_reg;
                    emit_kind_next = KIND_COMPLETE;
                    state_next     = ST_RD;
                end
                else if ((count_reg > PCNT_W'(max_pending)) && old_hit)
                begin
                    emit_idx_next  = old_idx;
                    emit_kind_next = KIND_FORCED;
                    state_next     = ST_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD:
            begin
                ram_re     = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (present_reg[emit_idx_reg][rd_ch_reg])
                begin
                    acc_next = merge_frag(acc_base, rd_word);
                end
                else
                begin
                    acc_next = acc_base;
                    acc_next.err[ERR_MISSING] = 1'b1;
                end
                if (rd_ch_reg == CH_W'(NUM_CHANNELS - 1))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    rd_ch_next = rd_ch_reg + CH_W'(1);
                    state_next = ST_RD;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_next.kind     = emit_kind_reg;
                    out_next.evt_num  = evnum_reg[emit_idx_reg];
                    out_next.acc      = acc_reg;
                    out_next.mask     = present_reg[emit_idx_reg];
                    out_valid_next    = 1'b1;
                    do_remove         = 1'b1;
                    state_next        = post_ins_reg ? ST_INS : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            count_reg     <= '0;
            for (int i = 0; i < MAX_PENDING; i++)
            begin
                present_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (do_remove)
            begin
                valid_reg[emit_idx_reg]   <= 1'b0;
                present_reg[emit_idx_reg] <= '0;
                count_reg                 <= count_reg - PCNT_W'(1);
            end
            else if (do_insert)
            begin
                present_reg[tgt_reg][cur_reg.channel] <= 1'b1;
                if (new_reg)
                begin
                    valid_reg[tgt_reg] <= 1'b1;
                    count_reg          <= count_reg + PCNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        tgt_reg       <= tgt_next;
        new_reg       <= new_next;
        produced_reg  <= produced_next;
        emit_idx_reg  <= emit_idx_next;
        emit_kind_reg <= emit_kind_next;
        post_ins_reg  <= post_ins_next;
        rd_ch_reg     <= rd_ch_next;
        acc_reg       <= acc_next;
        out_reg       <= out_next;
        if (do_remove)
        begin
            // Younger events move up one place in arrival order.
            for (int i = 0; i < MAX_PENDING; i++)
            begin
                if (valid_reg[i] && (rank_reg[i] > rank_reg[emit_idx_reg]))
                begin
                    rank_reg[i] <= rank_reg[i] - IDX_W'(1);
                end
            end
        end
        else if (do_insert && new_reg)
        begin
            evnum_reg[tgt_reg] <= cur_reg.evt_num;
            rank_reg[tgt_reg]  <= count_reg[IDX_W-1:0];
        end
    end

endmodule

[hdl/event_fragment_builder_top.sv]
// ----------------------------------------------------------------------------
// Event fragment builder
// Groups readout fragments into pending events and emits merged headers.
//
//   Channel   Handshake          Payload
//   input     push / full        channel .. fragment_bytes
//   result    empty / pop        kind .. payload_bytes
//   config    psel/penable/...   four registers at byte addresses 0, 4, 8, 12
//
// A fragment that joins a pending event passes the sequencer states IDLE,
// LOOK, INS and CHK; one that releases an event adds the RD and ACC states
// for each channel's fragment RAM read plus FIN to load the result.
// The front queue keeps accepting while the sequencer or the result waits, until it is full.
// Reset clears the event table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module event_fragment_builder_top
    import efb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                push,
    output logic                full,
    input  logic [CH_W-1:0]     channel,
    input  logic [31:0]         evt_num,
    input  logic [7:0]          frag_tag,
    input  logic [15:0]         trig_bits,
    input  logic [15:0]         bunch_id,
    input  logic [15:0]         frag_status,
    input  logic [63:0]         time_stamp,
    input  logic [15:0]         fragment_bytes,
    output logic                empty,
    input  logic                pop,
    output logic [1:0]          kind,
    output logic [31:0]         out_event_id,
    output logic [7:0]          out_tag,
    output logic [15:0]         merged_trigger,
    output logic [15:0]         out_bunch_id,
    output logic [15:0]         merged_status,
    output logic [63:0]         out_time_stamp,
    output logic [FCNT_W-1:0]   frag_count,
    output logic [NUM_CHANNELS-1:0] channel_mask,
    output logic [2:0]          error_flags,
    output logic [BYTES_W-1:0]  payload_bytes
);

    logic [3:0]  max_pending_reg;
    logic [7:0]  mon_tag_reg;
    logic [7:0]  trig_mon_tag_reg;
    logic [15:0] min_bytes_reg;
    logic        cfg_write;
    logic        q_valid;
    logic        q_pop;
    queue_item_t q_item;
    logic        out_valid;
    result_t     res;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_pending_reg  <= 4'd8;
            mon_tag_reg      <= 8'd2;
            trig_mon_tag_reg <= 8'd3;
            min_bytes_reg    <= 16'd24;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_MAX_PENDING: max_pending_reg  <= pwdata[3:0];
                REG_MON_TAG:     mon_tag_reg      <= pwdata[7:0];
                REG_TRIG_MON:    trig_mon_tag_reg <= pwdata[7:0];
                REG_MIN_BYTES:   min_bytes_reg    <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_MAX_PENDING: prdata = {28'd0, max_pending_reg};
            REG_MON_TAG:     prdata = {24'd0, mon_tag_reg};
            REG_TRIG_MON:    prdata = {24'd0, trig_mon_tag_reg};
            REG_MIN_BYTES:   prdata = {16'd0, min_bytes_reg};
            default:         prdata = 32'd0;
        endcase
    end

    efb_front u_front (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .push                   (push),
        .full                   (full),
        .channel                (channel),
        .evt_num                (evt_num),
        .frag_tag               (frag_tag),
        .trig_bits              (trig_bits),
        .bunch_id               (bunch_id),
        .frag_status            (frag_status),
        .time_stamp             (time_stamp),
        .fragment_bytes         (fragment_bytes),
        .monitoring_tag         (mon_tag_reg),
        .trigger_monitoring_tag (trig_mon_tag_reg),
        .min_fragment_bytes     (min_bytes_reg),
        .q_valid                (q_valid),
        .q_item                 (q_item),
        .q_pop                  (q_pop)
    );

    efb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .max_pending (max_pending_reg),
        .out_valid   (out_valid),
        .out_result  (res),
        .pop         (pop)
    );

    assign empty          = !out_valid;
    assign kind           = res.kind;
    assign out_event_id   = res.evt_num;
    assign out_tag        = res.acc.tag;
    assign merged_trigger = res.acc.trigger;
    assign out_bunch_id   = res.acc.bunch_id;
    assign merged_status  = res.acc.status;
    assign out_time_stamp = res.acc.time_stamp;
    assign frag_count     = res.acc.count;
    assign channel_mask   = res.mask;
    assign error_flags    = res.acc.err;
    assign payload_bytes  = res.acc.bytes;

endmodule
